/* sv/atgt_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal gap trim package
// Shared types, register indexes, status codes and reset values for the
// alignment terminal gap trim unit.
// ----------------------------------------------------------------------------
`default_nettype none

package atgt_pkg;

    // Default sizing of the alignment.
    localparam int MAX_ROWS_DEFAULT    = 1024;
    localparam int MAX_COLUMNS_DEFAULT = 4096;

    // Port widths fixed by the interface.
    localparam int SYMBOL_W      = 8;
    localparam int FRACTION_W    = 17;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 17;
    localparam int COLUMN_OUT_W  = 12;
    localparam int ROW_TOTAL_W   = 11;
    localparam int COL_TOTAL_W   = 13;
    localparam int STATUS_W      = 2;

    typedef logic [COLUMN_OUT_W-1:0] column_out_t;
    typedef logic [ROW_TOTAL_W-1:0]  row_total_t;
    typedef logic [COL_TOTAL_W-1:0]  col_total_t;
    typedef logic [CFG_INDEX_W-1:0]  cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_GAP_SYMBOL   = 2'd0;
    localparam cfg_index_t CFG_MAX_FRACTION = 2'd1;

    // Register reset values.
    localparam logic [SYMBOL_W-1:0]   GAP_SYMBOL_RESET   = 8'd45;
    localparam logic [FRACTION_W-1:0] MAX_FRACTION_RESET = 17'd32768;

    // Status codes, ordered by priority.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RAGGED   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_ACCUM  = 7'b0000010,
        ST_UPD_RD = 7'b0000100,
        ST_UPD_WR = 7'b0001000,
        ST_SETUP  = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* sv/alignment_terminal_gap_trim_unit.sv */
// ----------------------------------------------------------------------------
// Alignment terminal gap trim unit
// Streams an alignment symbol by symbol, histograms the row end positions and
// reports the column bounds whose terminal gap fraction is within threshold.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one symbol per request,
// row after row, with end_of_row and end_of_alignment marking the last
// symbol of a row and of the whole alignment. A symbol that does not close
// a row leaves the block ready for the next. A row that closes with at least
// one non-gap symbol passes a read and a write state for the read-modify-write
// of the two position histograms, which have one memory read and one write
// port each; in_stall is high meanwhile. The last symbol of the alignment
// starts a setup state and a scan through the histograms, one column per
// cycle, that evaluates the prefix sums and writes each entry back to zero.
// The single result request then waits on out_valid until out_stall is low;
// no new symbol is taken until it has been delivered.
// After reset the histogram memories are cleared by a pass over their
// MAX_COLUMNS entries while in_stall stays high. Configuration writes on the
// cfg_valid / cfg_ready port are taken in every cycle, including that pass,
// and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module alignment_terminal_gap_trim_unit #(
    parameter int MAX_ROWS    = atgt_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLUMNS = atgt_pkg::MAX_COLUMNS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [atgt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [atgt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Symbol input channel.
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [atgt_pkg::SYMBOL_W-1:0]     symbol,
    input  wire logic                              end_of_row,
    input  wire logic                              end_of_alignment,
    // Result channel.
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [atgt_pkg::COLUMN_OUT_W-1:0]      start_column,
    output logic [atgt_pkg::COLUMN_OUT_W-1:0]      end_column,
    output logic [atgt_pkg::ROW_TOTAL_W-1:0]       row_total,
    output logic [atgt_pkg::COL_TOTAL_W-1:0]       column_total,
    output logic [atgt_pkg::STATUS_W-1:0]          status
);

    // Column counters must hold MAX_COLUMNS itself; addresses only index it.
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    // Row counters and histogram entries must hold MAX_ROWS itself.
    localparam int RW = $clog2(MAX_ROWS + 1);
    // Width of the threshold product and of the terminal count.
    localparam int LW = atgt_pkg::FRACTION_W + RW;
    localparam int TW = RW + 2;

    atgt_pkg::state_t state_reg, state_next;

    logic [atgt_pkg::SYMBOL_W-1:0]   gap_reg, gap_next;
    logic [atgt_pkg::FRACTION_W-1:0] frac_reg, frac_next;

    // Row tracking state.
    logic [CW-1:0] col_idx_reg, col_idx_next;
    logic [CW-1:0] row_width_reg, row_width_next;
    logic [AW-1:0] fn_reg, fn_next;
    logic [AW-1:0] ln_reg, ln_next;
    logic          seen_reg, seen_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [RW-1:0] all_gap_reg, all_gap_next;
    atgt_pkg::status_t err_reg, err_next;

    // Pending histogram update.
    logic [AW-1:0] upd_first_reg, upd_first_next;
    logic [AW-1:0] upd_last_reg, upd_last_next;
    logic          eoa_pend_reg, eoa_pend_next;

    // Scan and clear sequencer.
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          scan_vld_reg, scan_vld_next;
    logic [AW-1:0] scan_col_reg, scan_col_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [RW-1:0] nongap_reg, nongap_next;
    logic [RW-1:0] first_le_reg, first_le_next;
    logic [RW-1:0] last_lt_reg, last_lt_next;
    logic          found_reg, found_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] end_reg, end_next;
    logic          out_valid_reg, out_valid_next;

    // Histogram memories and their ports.
    logic [RW-1:0] first_mem [MAX_COLUMNS];
    logic [RW-1:0] last_mem  [MAX_COLUMNS];
    logic [RW-1:0] f_rd_reg;
    logic [RW-1:0] l_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] f_waddr;
    logic [AW-1:0] l_waddr;
    logic [RW-1:0] f_wdata;
    logic [RW-1:0] l_wdata;

    // Scan datapath.
    logic [RW-1:0] first_le_sum;
    logic [TW-1:0] terminal;
    logic [TW-1:0] threshold;
    logic          col_ok;
    logic [AW-1:0] last_column;

    // Symbol accept helpers.
    logic          in_accept;
    logic          col_full;
    logic          is_nongap;
    logic          row_close;
    logic [CW-1:0] col_after;
    logic          seen_after;
    logic [AW-1:0] fn_after;
    logic [AW-1:0] ln_after;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != atgt_pkg::ST_ACCUM);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign start_column = atgt_pkg::column_out_t'(start_reg);
    assign end_column   = atgt_pkg::column_out_t'(end_reg);
    assign row_total    = atgt_pkg::row_total_t'(row_count_reg);
    assign column_total = atgt_pkg::col_total_t'(row_width_reg);
    assign status       = err_reg;

    // The threshold test count * 65536 <= limit reduces to count <= limit >> 16.
    assign threshold    = TW'(limit_reg[LW-1:16]);
    assign first_le_sum = first_le_reg + f_rd_reg;
    assign terminal     = TW'(nongap_reg) - TW'(first_le_sum)
                        + TW'(last_lt_reg) + TW'(all_gap_reg);
    assign col_ok       = scan_vld_reg && (terminal <= threshold)
                        && (CW'(scan_col_reg) < row_width_reg);
    assign last_column  = (row_width_reg != '0) ? AW'(row_width_reg - CW'(1)) : '0;

    assign col_full   = (col_idx_reg == CW'(MAX_COLUMNS));
    assign is_nongap  = (symbol != gap_reg);
    assign row_close  = end_of_row || end_of_alignment;
    assign col_after  = col_full ? col_idx_reg : col_idx_reg + CW'(1);
    assign seen_after = seen_reg || (!col_full && is_nongap);
    assign fn_after   = (!col_full && is_nongap && !seen_reg) ? AW'(col_idx_reg) : fn_reg;
    assign ln_after   = (!col_full && is_nongap) ? AW'(col_idx_reg) : ln_reg;

    always_comb
    begin
        state_next     = state_reg;
        gap_next       = gap_reg;
        frac_next      = frac_reg;
        col_idx_next   = col_idx_reg;
        row_width_next = row_width_reg;
        fn_next        = fn_reg;
        ln_next        = ln_reg;
        seen_next      = seen_reg;
        row_count_next = row_count_reg;
        all_gap_next   = all_gap_reg;
        err_next       = err_reg;
        upd_first_next = upd_first_reg;
        upd_last_next  = upd_last_reg;
        eoa_pend_next  = eoa_pend_reg;
        cnt_next       = cnt_reg;
        scan_vld_next  = 1'b0;
        scan_col_next  = scan_col_reg;
        limit_next     = limit_reg;
        nongap_next    = nongap_reg;
        first_le_next  = first_le_reg;
        last_lt_next   = last_lt_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        rd_addr        = cnt_reg[AW-1:0];
        mem_we         = 1'b0;
        f_waddr        = cnt_reg[AW-1:0];
        l_waddr        = cnt_reg[AW-1:0];
        f_wdata        = '0;
        l_wdata        = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                atgt_pkg::CFG_GAP_SYMBOL:   gap_next  = cfg_data[atgt_pkg::SYMBOL_W-1:0];
                atgt_pkg::CFG_MAX_FRACTION: frac_next = cfg_data[atgt_pkg::FRACTION_W-1:0];
                default:                    ;
            endcase
        end

        case (state_reg)
            atgt_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CW'(MAX_COLUMNS - 1))
                begin
                    cnt_next   = '0;
                    state_next = atgt_pkg::ST_ACCUM;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            atgt_pkg::ST_ACCUM:
            begin
                if (in_accept)
                begin
                    col_idx_next = col_after;
                    seen_next    = seen_after;
                    fn_next      = fn_after;
                    ln_next      = ln_after;
                    if (col_full)
                    begin
                        err_next = atgt_pkg::STATUS_OVERFLOW;
                    end
                    if (row_close)
                    begin
                        eoa_pend_next = end_of_alignment;
                        if (row_count_reg == RW'(MAX_ROWS))
                        begin
                            err_next = atgt_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            if (row_count_reg == '0)
                            begin
                                row_width_next = col_after;
                            end
                            else if ((col_after != row_width_reg)
                                     && (err_next != atgt_pkg::STATUS_OVERFLOW))
                            begin
                                err_next = atgt_pkg::STATUS_RAGGED;
                            end
                            if (!seen_after)
                            begin
                                all_gap_next = all_gap_reg + RW'(1);
                            end
                            row_count_next = row_count_reg + RW'(1);
                        end
                        col_idx_next   = '0;
                        fn_next        = '0;
                        ln_next        = '0;
                        seen_next      = 1'b0;
                        upd_first_next = fn_after;
                        upd_last_next  = ln_after;
                        if ((row_count_reg != RW'(MAX_ROWS)) && seen_after)
                        begin
                            state_next = atgt_pkg::ST_UPD_RD;
                        end
                        else if (end_of_alignment)
                        begin
                            state_next = atgt_pkg::ST_SETUP;
                        end
                    end
                end
            end

            atgt_pkg::ST_UPD_RD:
            begin
                // Both histograms read at their own entry: first at rd_addr, last at upd_last_reg.
                rd_addr    = upd_first_reg;
                state_next = atgt_pkg::ST_UPD_WR;
            end

            atgt_pkg::ST_UPD_WR:
            begin
                mem_we     = 1'b1;
                f_waddr    = upd_first_reg;
                l_waddr    = upd_last_reg;
                f_wdata    = f_rd_reg + RW'(1);
                l_wdata    = l_rd_reg + RW'(1);
                state_next = eoa_pend_reg ? atgt_pkg::ST_SETUP : atgt_pkg::ST_ACCUM;
            end

            atgt_pkg::ST_SETUP:
            begin
                limit_next    = LW'(frac_reg) * LW'(row_count_reg);
                nongap_next   = row_count_reg - all_gap_reg;
                first_le_next = '0;
                last_lt_next  = '0;
                found_next    = 1'b0;
                start_next    = '0;
                end_next      = '0;
                cnt_next      = '0;
                state_next    = atgt_pkg::ST_SCAN;
            end

            atgt_pkg::ST_SCAN:
            begin
                // Issue one column read per cycle while columns remain.
                if (cnt_reg != CW'(MAX_COLUMNS))
                begin
                    scan_vld_next = 1'b1;
                    scan_col_next = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + CW'(1);
                end
                // Evaluate the column whose data has arrived, then zero it.
                if (scan_vld_reg)
                begin
                    mem_we        = 1'b1;
                    f_waddr       = scan_col_reg;
                    l_waddr       = scan_col_reg;
                    first_le_next = first_le_sum;
                    last_lt_next  = last_lt_reg + l_rd_reg;
                    if (col_ok)
                    begin
                        if (!found_reg)
                        begin
                            start_next = scan_col_reg;
                        end
                        end_next   = scan_col_reg;
                        found_next = 1'b1;
                    end
                    if (scan_col_reg == AW'(MAX_COLUMNS - 1))
                    begin
                        // With no qualifying column the whole width is kept.
                        if (!found_next)
                        begin
                            start_next = '0;
                            end_next   = last_column;
                        end
                        scan_vld_next  = 1'b0;
                        cnt_next       = '0;
                        out_valid_next = 1'b1;
                        state_next     = atgt_pkg::ST_OUT;
                    end
                end
            end

            atgt_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    row_count_next = '0;
                    row_width_next = '0;
                    all_gap_next   = '0;
                    err_next       = atgt_pkg::STATUS_OK;
                    eoa_pend_next  = 1'b0;
                    state_next     = atgt_pkg::ST_ACCUM;
                end
            end

            default:
            begin
                state_next = atgt_pkg::ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atgt_pkg::ST_CLEAR;
            gap_reg       <= atgt_pkg::GAP_SYMBOL_RESET;
            frac_reg      <= atgt_pkg::MAX_FRACTION_RESET;
            col_idx_reg   <= '0;
            row_width_reg <= '0;
            fn_reg        <= '0;
            ln_reg        <= '0;
            seen_reg      <= 1'b0;
            row_count_reg <= '0;
            all_gap_reg   <= '0;
            err_reg       <= atgt_pkg::STATUS_OK;
            eoa_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
            scan_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_reg       <= gap_next;
            frac_reg      <= frac_next;
            col_idx_reg   <= col_idx_next;
            row_width_reg <= row_width_next;
            fn_reg        <= fn_next;
            ln_reg        <= ln_next;
            seen_reg      <= seen_next;
            row_count_reg <= row_count_next;
            all_gap_reg   <= all_gap_next;
            err_reg       <= err_next;
            eoa_pend_reg  <= eoa_pend_next;
            cnt_reg       <= cnt_next;
            scan_vld_reg  <= scan_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers; their values are only used under the control above.
    always_ff @(posedge clk)
    begin
        upd_first_reg <= upd_first_next;
        upd_last_reg  <= upd_last_next;
        scan_col_reg  <= scan_col_next;
        limit_reg     <= limit_next;
        nongap_reg    <= nongap_next;
        first_le_reg  <= first_le_next;
        last_lt_reg   <= last_lt_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
    end

    // Position histograms: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            first_mem[f_waddr] <= f_wdata;
            last_mem[l_waddr]  <= l_wdata;
        end
        f_rd_reg <= first_mem[rd_addr];
        l_rd_reg <= last_mem[(state_reg == atgt_pkg::ST_UPD_RD) ? upd_last_reg : rd_addr];
    end

endmodule

`default_nettype wire
